FILE: rtl/ffct_pkg.sv
// Shared types and constants for the frame fence completion tracker.
package ffct_pkg;

  localparam int FENCE_W = 64;
  localparam int FRAME_W = 64;
  localparam int QMASK_W = 3;
  localparam int COUNT_W = 5;
  localparam int TRACK_W = 2;
  localparam int STATUS_W = 2;
  localparam int PENDING_DEPTH_DEFAULT = 16;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_POLL    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL         = 2'd2;

  typedef enum logic {
    FSM_IDLE,
    FSM_WALK
  } fsm_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [FENCE_W-1:0] gfx_target;
    logic [FENCE_W-1:0] cmp_target;
    logic [FENCE_W-1:0] xfr_target;
    logic [QMASK_W-1:0] qmask;
  } entry_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  last_completed_frame;
    logic [FRAME_W-1:0]  last_captured_frame;
    logic [COUNT_W-1:0]  pending_count;
    logic [TRACK_W-1:0]  tracked_queue_count;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

FILE: rtl/ffct_if.sv
// Valid/ready channel interfaces for the command and result transactions.
interface ffct_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [ffct_pkg::FRAME_W-1:0] frame_number;
  logic [ffct_pkg::QMASK_W-1:0] queue_mask;
  logic [ffct_pkg::FENCE_W-1:0] graphics_fence;
  logic [ffct_pkg::FENCE_W-1:0] compute_fence;
  logic [ffct_pkg::FENCE_W-1:0] transfer_fence;

  modport source (
    output valid, command, frame_number, queue_mask,
           graphics_fence, compute_fence, transfer_fence,
    input  ready
  );
  modport sink (
    input  valid, command, frame_number, queue_mask,
           graphics_fence, compute_fence, transfer_fence,
    output ready
  );
endinterface

interface ffct_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffct_pkg::FRAME_W-1:0]  last_completed_frame;
  logic [ffct_pkg::FRAME_W-1:0]  last_captured_frame;
  logic [ffct_pkg::COUNT_W-1:0]  pending_count;
  logic [ffct_pkg::TRACK_W-1:0]  tracked_queue_count;
  logic [ffct_pkg::STATUS_W-1:0] status;

  modport source (
    output valid, last_completed_frame, last_captured_frame, pending_count,
           tracked_queue_count, status,
    input  ready
  );
  modport sink (
    input  valid, last_completed_frame, last_captured_frame, pending_count,
           tracked_queue_count, status,
    output ready
  );
endinterface

FILE: rtl/ffct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/frame_fence_completion_tracker.sv
// Top level: frame fence completion tracker with a RAM-backed pending ring.
//
//  channel   dir  transaction
//  in_chan   in   capture (command 0) or poll (command 1) with three fences
//  out_chan  out  one result per command: frames, pending count, status
//
// A capture's result is loaded into the output register when the capture is accepted.
// A poll walks the ring: the accept cycle primes the RAM read port, then one head
// entry is checked per cycle, each done head is retired, and the walk ends at a
// blocked or empty head, whose result is then loaded into the output register.
// Synchronous active-low reset clears pointers, counters and the result slot;
// the ring RAM is not cleared, only entries between head and tail are read.
// A new command is taken when no poll walk is running and the result slot is
// empty or being drained.
module frame_fence_completion_tracker #(
  parameter int PENDING_DEPTH = ffct_pkg::PENDING_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  ffct_in_if.sink    in_chan,
  ffct_out_if.source out_chan
);
  import ffct_pkg::*;

  localparam int PTR_W = $clog2(PENDING_DEPTH);
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(PENDING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PENDING_DEPTH);

  fsm_t               state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] captured_r, captured_nxt;
  logic [FRAME_W-1:0] completed_r, completed_nxt;
  logic [TRACK_W-1:0] tracked_r, tracked_nxt;
  logic [FENCE_W-1:0] gfx_r, gfx_nxt;
  logic [FENCE_W-1:0] cmp_r, cmp_nxt;
  logic [FENCE_W-1:0] xfr_r, xfr_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r, res_nxt;

  entry_t             wr_entry;
  entry_t             head_entry;
  logic               wr_en;
  logic               accept;
  logic               head_done;
  logic [STATUS_W-1:0] cap_status;

  function automatic logic [FENCE_W-1:0] target_of(input logic present,
                                                   input logic [FENCE_W-1:0] nf);
    if (!present || nf == '0) begin
      return '0;
    end
    return nf - FENCE_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  ffct_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (PENDING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (wr_entry),
    .rd_addr (head_nxt),
    .rd_data (head_entry)
  );

  assign in_chan.ready = (state_r == FSM_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid                = out_valid_r;
  assign out_chan.last_completed_frame = res_r.last_completed_frame;
  assign out_chan.last_captured_frame  = res_r.last_captured_frame;
  assign out_chan.pending_count        = res_r.pending_count;
  assign out_chan.tracked_queue_count  = res_r.tracked_queue_count;
  assign out_chan.status               = res_r.status;

  always_comb begin
    wr_entry.frame      = in_chan.frame_number;
    wr_entry.qmask      = in_chan.queue_mask;
    wr_entry.gfx_target = target_of(in_chan.queue_mask[0], in_chan.graphics_fence);
    wr_entry.cmp_target = target_of(in_chan.queue_mask[1], in_chan.compute_fence);
    wr_entry.xfr_target = target_of(in_chan.queue_mask[2], in_chan.transfer_fence);

    if (in_chan.frame_number <= captured_r) begin
      cap_status = ST_OUT_OF_ORDER;
    end else if (cnt_r >= CNT_FULL) begin
      cap_status = ST_FULL;
    end else begin
      cap_status = ST_OK;
    end

    head_done = (cnt_r != '0)
             && !(head_entry.qmask[0] && gfx_r < head_entry.gfx_target)
             && !(head_entry.qmask[1] && cmp_r < head_entry.cmp_target)
             && !(head_entry.qmask[2] && xfr_r < head_entry.xfr_target);
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    captured_nxt  = captured_r;
    completed_nxt = completed_r;
    tracked_nxt   = tracked_r;
    gfx_nxt       = gfx_r;
    cmp_nxt       = cmp_r;
    xfr_nxt       = xfr_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    wr_en         = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          if (in_chan.command == CMD_CAPTURE) begin
            res_nxt.last_completed_frame = completed_r;
            res_nxt.last_captured_frame  = captured_r;
            res_nxt.pending_count        = COUNT_W'(cnt_r);
            res_nxt.tracked_queue_count  = tracked_r;
            res_nxt.status               = cap_status;
            if (cap_status == ST_OK) begin
              wr_en        = 1'b1;
              tail_nxt     = ring_next(tail_r);
              cnt_nxt      = cnt_r + CNT_W'(1);
              captured_nxt = in_chan.frame_number;
              tracked_nxt  = TRACK_W'(in_chan.queue_mask[0])
                           + TRACK_W'(in_chan.queue_mask[1])
                           + TRACK_W'(in_chan.queue_mask[2]);
              res_nxt.last_captured_frame = in_chan.frame_number;
              res_nxt.pending_count       = COUNT_W'(cnt_nxt);
              res_nxt.tracked_queue_count = tracked_nxt;
            end
            out_valid_nxt = 1'b1;
          end else begin
            gfx_nxt   = in_chan.graphics_fence;
            cmp_nxt   = in_chan.compute_fence;
            xfr_nxt   = in_chan.transfer_fence;
            state_nxt = FSM_WALK;
          end
        end
      end
      FSM_WALK: begin
        if (head_done) begin
          completed_nxt = head_entry.frame;
          head_nxt      = ring_next(head_r);
          cnt_nxt       = cnt_r - CNT_W'(1);
        end else begin
          res_nxt.last_completed_frame = completed_r;
          res_nxt.last_captured_frame  = captured_r;
          res_nxt.pending_count        = COUNT_W'(cnt_r);
          res_nxt.tracked_queue_count  = tracked_r;
          res_nxt.status               = ST_OK;
          out_valid_nxt                = 1'b1;
          state_nxt                    = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      captured_r  <= '0;
      completed_r <= '0;
      tracked_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      captured_r  <= captured_nxt;
      completed_r <= completed_nxt;
      tracked_r   <= tracked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gfx_r <= gfx_nxt;
    cmp_r <= cmp_nxt;
    xfr_r <= xfr_nxt;
    res_r <= res_nxt;
  end

endmodule

FILE: test/frame_fence_completion_tracker_test.sv
// Self-checking testbench for the frame fence completion tracker.
`timescale 1ns / 100ps

module frame_fence_completion_tracker_test;
  import ffct_pkg::*;

  localparam int DEPTH       = PENDING_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [FENCE_W-1:0] FENCE_MAX = '1;

  typedef struct packed {
    logic               command;
    logic [FRAME_W-1:0] frame;
    logic [QMASK_W-1:0] mask;
    logic [FENCE_W-1:0] gfx;
    logic [FENCE_W-1:0] cmp;
    logic [FENCE_W-1:0] xfr;
  } frame_cmd_t;

  logic clk;
  logic rst_n;

  ffct_in_if  in_chan ();
  ffct_out_if out_chan ();

  frame_fence_completion_tracker DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  frame_cmd_t cmd_queue[$];
  result_t    expected_reports[$];

  // predictor state
  logic [FRAME_W-1:0] ring_frame [DEPTH];
  logic [FENCE_W-1:0] ring_gfx   [DEPTH];
  logic [FENCE_W-1:0] ring_cmp   [DEPTH];
  logic [FENCE_W-1:0] ring_xfr   [DEPTH];
  logic [QMASK_W-1:0] ring_mask  [DEPTH];
  int                 ring_head;
  int                 ring_tail;
  int                 frames_pending;
  logic [FRAME_W-1:0] newest_frame;
  logic [FRAME_W-1:0] retired_frame;
  logic [TRACK_W-1:0] tracked_count;

  int n_stored, n_out_of_order, n_full, n_polls, n_retired, n_checked;
  int mismatches;
  int sender_idle_pct;
  int stall_pct;
  int cycle_count;
  logic cmd_taken;
  logic hold_trigger;
  logic hold_seen;
  int   hold_left;

  // generator state for well-formed sequences
  longint unsigned gen_frame;
  longint unsigned sub_next [3];
  longint unsigned done_fence [3];

  function automatic logic [FENCE_W-1:0] fence_target(logic [FENCE_W-1:0] next_fence);
    return (next_fence == '0) ? '0 : next_fence - FENCE_W'(1);
  endfunction

  function automatic result_t predict_report(frame_cmd_t cmd);
    result_t            rep;
    logic [STATUS_W-1:0] st;
    logic [QMASK_W-1:0]  m;
    st = ST_OK;
    if (cmd.command == CMD_CAPTURE) begin
      if (cmd.frame <= newest_frame) begin
        st = ST_OUT_OF_ORDER;
        n_out_of_order++;
      end else if (frames_pending >= DEPTH) begin
        st = ST_FULL;
        n_full++;
      end else begin
        ring_frame[ring_tail] = cmd.frame;
        ring_mask[ring_tail]  = cmd.mask;
        ring_gfx[ring_tail]   = cmd.mask[0] ? fence_target(cmd.gfx) : '0;
        ring_cmp[ring_tail]   = cmd.mask[1] ? fence_target(cmd.cmp) : '0;
        ring_xfr[ring_tail]   = cmd.mask[2] ? fence_target(cmd.xfr) : '0;
        ring_tail = (ring_tail + 1) % DEPTH;
        frames_pending++;
        newest_frame  = cmd.frame;
        tracked_count = TRACK_W'($countones(cmd.mask));
        n_stored++;
      end
    end else begin
      n_polls++;
      while (frames_pending > 0) begin
        m = ring_mask[ring_head];
        if ((m[0] && cmd.gfx < ring_gfx[ring_head]) ||
            (m[1] && cmd.cmp < ring_cmp[ring_head]) ||
            (m[2] && cmd.xfr < ring_xfr[ring_head]))
          break;
        retired_frame = ring_frame[ring_head];
        ring_head = (ring_head + 1) % DEPTH;
        frames_pending--;
        n_retired++;
      end
    end
    rep.last_completed_frame = retired_frame;
    rep.last_captured_frame  = newest_frame;
    rep.pending_count        = COUNT_W'(frames_pending);
    rep.tracked_queue_count  = tracked_count;
    rep.status               = st;
    return rep;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_capture(logic [FRAME_W-1:0] frame, logic [QMASK_W-1:0] mask,
                              logic [FENCE_W-1:0] g, logic [FENCE_W-1:0] c,
                              logic [FENCE_W-1:0] x);
    frame_cmd_t cmd;
    cmd.command = CMD_CAPTURE;
    cmd.frame   = frame;
    cmd.mask    = mask;
    cmd.gfx     = g;
    cmd.cmp     = c;
    cmd.xfr     = x;
    cmd_queue.push_back(cmd);
  endtask

  // frame and mask are don't-care on a poll, so they carry noise
  task automatic push_poll(logic [FENCE_W-1:0] g, logic [FENCE_W-1:0] c,
                           logic [FENCE_W-1:0] x);
    frame_cmd_t cmd;
    cmd.command = CMD_POLL;
    cmd.frame   = rand64();
    cmd.mask    = QMASK_W'($urandom_range(0, 7));
    cmd.gfx     = g;
    cmd.cmp     = c;
    cmd.xfr     = x;
    cmd_queue.push_back(cmd);
  endtask

  task automatic push_random(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        gen_frame += $urandom_range(1, 4);
        for (int q = 0; q < 3; q++) sub_next[q] += $urandom_range(0, 3);
        push_capture(gen_frame, QMASK_W'($urandom_range(0, 7)),
                     sub_next[0], sub_next[1], sub_next[2]);
      end else if (pick < 82) begin
        for (int q = 0; q < 3; q++)
          done_fence[q] += $urandom_range(0, 32'(sub_next[q] - done_fence[q]));
        push_poll(done_fence[0], done_fence[1], done_fence[2]);
      end else if (pick < 88) begin
        push_poll(FENCE_MAX, FENCE_MAX, FENCE_MAX);
      end else if (pick < 94) begin
        push_capture(64'($urandom_range(0, 32'(gen_frame))), QMASK_W'($urandom_range(0, 7)),
                     rand64(), rand64(), rand64());
      end else begin
        push_poll(rand64(), rand64(), rand64());
      end
    end
  endtask

  task automatic wait_queue_empty();
    while (cmd_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk                      = 1'b0;
    rst_n                    = 1'b0;
    in_chan.valid            = 1'b0;
    in_chan.command          = CMD_CAPTURE;
    in_chan.frame_number     = '0;
    in_chan.queue_mask       = '0;
    in_chan.graphics_fence   = '0;
    in_chan.compute_fence    = '0;
    in_chan.transfer_fence   = '0;
    out_chan.ready           = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // command driver
  always @(negedge clk) begin : drive_cmds
    frame_cmd_t cmd;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (in_chan.valid && !cmd_taken) begin
      // hold until taken
    end else if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      cmd = cmd_queue.pop_front();
      in_chan.valid          <= 1'b1;
      in_chan.command        <= cmd.command;
      in_chan.frame_number   <= cmd.frame;
      in_chan.queue_mask     <= cmd.mask;
      in_chan.graphics_fence <= cmd.gfx;
      in_chan.compute_fence  <= cmd.cmp;
      in_chan.transfer_fence <= cmd.xfr;
    end else begin
      in_chan.valid <= 1'b0;
    end
  end

  // result receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_seen      <= hold_trigger;
      hold_left      <= 0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen      <= hold_trigger;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // prediction on accepted commands, checking on accepted results
  always @(posedge clk) begin : track_and_check
    frame_cmd_t cmd;
    result_t    exp;
    result_t    act;
    if (!rst_n) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        cmd.command = in_chan.command;
        cmd.frame   = in_chan.frame_number;
        cmd.mask    = in_chan.queue_mask;
        cmd.gfx     = in_chan.graphics_fence;
        cmd.cmp     = in_chan.compute_fence;
        cmd.xfr     = in_chan.transfer_fence;
        expected_reports.push_back(predict_report(cmd));
      end
      if (out_chan.valid && out_chan.ready) begin
        act.last_completed_frame = out_chan.last_completed_frame;
        act.last_captured_frame  = out_chan.last_captured_frame;
        act.pending_count        = out_chan.pending_count;
        act.tracked_queue_count  = out_chan.tracked_queue_count;
        act.status               = out_chan.status;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result transaction: completed=%0h captured=%0h",
                     $realtime, act.last_completed_frame, act.last_captured_frame);
        end else begin
          exp = expected_reports.pop_front();
          n_checked++;
          if (act.last_completed_frame !== exp.last_completed_frame ||
              act.last_captured_frame  !== exp.last_captured_frame  ||
              act.pending_count        !== exp.pending_count        ||
              act.tracked_queue_count  !== exp.tracked_queue_count  ||
              act.status               !== exp.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result %0d: completed exp %0h got %0h, captured exp %0h got %0h",
                       $realtime, n_checked, exp.last_completed_frame,
                       act.last_completed_frame, exp.last_captured_frame,
                       act.last_captured_frame);
              $display("  pending exp %0d got %0d, tracked exp %0d got %0d, status exp %0d got %0d",
                       exp.pending_count, act.pending_count, exp.tracked_queue_count,
                       act.tracked_queue_count, exp.status, act.status);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_reports.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    ring_head       = 0;
    ring_tail       = 0;
    frames_pending  = 0;
    newest_frame    = '0;
    retired_frame   = '0;
    tracked_count   = '0;
    n_stored        = 0;
    n_out_of_order  = 0;
    n_full          = 0;
    n_polls         = 0;
    n_retired       = 0;
    n_checked       = 0;
    mismatches      = 0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    cycle_count     = 0;
    hold_trigger    = 1'b0;
    gen_frame       = 17;
    for (int q = 0; q < 3; q++) begin
      sub_next[q]   = 0;
      done_fence[q] = 0;
    end

    // directed: frame zero refused after reset, empty mask retires at once
    push_capture(64'd0, 3'b111, 64'd5, 64'd5, 64'd5);
    push_capture(64'd1, 3'b000, rand64(), rand64(), rand64());
    push_poll('0, '0, '0);
    // fill the store: saturation at zero, single queue, mixed masks
    push_capture(64'd2, 3'b111, '0, '0, '0);
    push_capture(64'd3, 3'b001, 64'd100, FENCE_MAX, FENCE_MAX);
    for (int i = 4; i < 18; i++)
      push_capture(64'(i), QMASK_W'(i % 8), 64'(100 + i), 64'(200 + i), 64'(300 + i));
    push_capture(64'd18, 3'b111, '0, '0, '0);
    push_capture(64'd17, 3'b111, '0, '0, '0);
    push_poll(64'd99, '0, '0);
    push_poll(FENCE_MAX, FENCE_MAX, FENCE_MAX);

    @(posedge rst_n);
    wait_queue_empty();
    push_random(160);
    wait_queue_empty();

    sender_idle_pct = 87;
    push_random(120);
    wait_queue_empty();

    sender_idle_pct = 0;
    stall_pct       = 87;
    push_random(120);
    wait_queue_empty();

    sender_idle_pct = 38;
    stall_pct       = 38;
    push_random(150);
    wait_queue_empty();

    // receiver holds off while commands keep coming
    sender_idle_pct = 0;
    stall_pct       = 0;
    push_random(100);
    @(posedge clk);
    hold_trigger = ~hold_trigger;
    wait_queue_empty();

    // top frame number and top fences
    push_poll(FENCE_MAX, FENCE_MAX, FENCE_MAX);
    push_capture(FENCE_MAX, 3'b111, FENCE_MAX, FENCE_MAX, FENCE_MAX);
    push_poll(FENCE_MAX - 2, FENCE_MAX, FENCE_MAX);
    push_poll(FENCE_MAX - 1, FENCE_MAX - 1, FENCE_MAX - 1);
    push_capture(rand64(), 3'b111, rand64(), rand64(), rand64());

    while (cmd_queue.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Checked %0d results: %0d frames stored, %0d refused out of order, %0d refused full",
             n_checked, n_stored, n_out_of_order, n_full);
    $display("%0d polls retired %0d frames over %0d cycles", n_polls, n_retired, cycle_count);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: frame_fence_completion_tracker.f
rtl/ffct_pkg.sv
rtl/ffct_if.sv
rtl/ffct_ram.sv
rtl/frame_fence_completion_tracker.sv
test/frame_fence_completion_tracker_test.sv
